[rtl/ccfp_pkg.sv]
// shared types, constants and crc byte-update functions for the frame parser
package ccfp_pkg;

    localparam logic [7:0]  SOF_BYTE         = 8'hA5;
    localparam logic [7:0]  HDR_CRC_INIT     = 8'hFF;
    localparam logic [15:0] FRM_CRC_INIT     = 16'hFFFF;
    localparam logic [7:0]  HDR_CRC_POLY     = 8'h8C;
    localparam logic [15:0] FRM_CRC_POLY     = 16'h8408;
    localparam logic [15:0] MAX_DATA_LEN_RST = 16'd128;

    // report status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_HDR_CRC = 2'd1;
    localparam logic [1:0] ST_LEN     = 2'd2;
    localparam logic [1:0] ST_FRM_CRC = 2'd3;

    // result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [15:0] data_index;
        logic [15:0] command_id;
        logic [7:0]  sequence_res;
        logic [1:0]  status;
        logic        frame_last;
    } result_t;

    // reflected crc8, one byte per call
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        begin
            c = crc ^ b;
            for (int k = 0; k < 8; k++)
            begin
                c = c[0] ? ((c >> 1) ^ HDR_CRC_POLY) : (c >> 1);
            end
            return c;
        end
    endfunction

    // reflected ccitt crc16, one byte per call
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        begin
            c = crc ^ {8'h00, b};
            for (int k = 0; k < 8; k++)
            begin
                c = c[0] ? ((c >> 1) ^ FRM_CRC_POLY) : (c >> 1);
            end
            return c;
        end
    endfunction

endpackage

[rtl/ccfp_out_reg.sv]
// result register with backpressure toward the parser
module ccfp_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_valid,
    input  ccfp_pkg::result_t load_data,
    input  logic              out_stall,
    output logic              hold,
    output logic              out_valid,
    output ccfp_pkg::result_t out_data
);

    logic              valid_reg;
    ccfp_pkg::result_t data_reg;

    // register busy and not drained this cycle
    assign hold      = valid_reg && out_stall;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!hold)
        begin
            valid_reg <= load_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && !hold)
        begin
            data_reg <= load_data;
        end
    end

endmodule

[rtl/crc_checked_frame_parser_unit.sv]
// byte-stream deframer with header crc8, frame crc16 and length limit
//
//  channel   signals                                    dir   notes
//  in        in_valid, in_stall, rx_byte                in    one received byte per item
//  out       out_valid, out_stall, kind, data_byte,     out   data byte or end-of-frame report
//            data_index, command_id, sequence_res,
//            status, frame_last
//  cfg       cfg_wr_en, cfg_wr_data                     in    max_data_len, no read-back
//
// one byte per cycle sustained while in_stall is low; the crc8/crc16 byte updates
// and the phase decode sit between the parser state registers and the result register
// a result is registered and appears on out in the cycle after the byte that caused it is accepted
// in_stall rises only while a result is held in the output register under out_stall
// reset puts the parser in hunt with crcs at their init values and max_data_len at 128
module crc_checked_frame_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    // input byte channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [7:0]  data_byte,
    output logic [15:0] data_index,
    output logic [15:0] command_id,
    output logic [7:0]  sequence_res,
    output logic [1:0]  status,
    output logic        frame_last,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_HEADER = 3'd1,
        PH_CMD    = 3'd2,
        PH_DATA   = 3'd3,
        PH_CRC    = 3'd4
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;          // position within current phase
    logic [15:0] len_reg, len_next;          // data length from header
    logic [7:0]  hcrc_reg, hcrc_next;        // running header crc8
    logic [15:0] fcrc_reg, fcrc_next;        // running frame crc16
    logic [7:0]  seq_reg, seq_next;          // sequence byte of latest header
    logic [15:0] cmd_reg, cmd_next;          // command id being assembled
    logic [7:0]  crc_lo_reg, crc_lo_next;    // low byte of received crc16
    logic [15:0] max_len_reg;

    logic              in_accept;
    logic              res_valid;
    ccfp_pkg::result_t res;
    ccfp_pkg::result_t out_data;
    logic              data_done;

    assign in_accept = in_valid && !in_stall;

    // last data byte of the frame
    assign data_done = ({1'b0, pos_reg} + 17'd1) >= {1'b0, len_reg};

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        hcrc_next   = hcrc_reg;
        fcrc_next   = fcrc_reg;
        seq_next    = seq_reg;
        cmd_next    = cmd_reg;
        crc_lo_next = crc_lo_reg;

        res_valid        = 1'b0;
        res.kind         = ccfp_pkg::KIND_REPORT;
        res.data_byte    = 8'h00;
        res.data_index   = 16'h0000;
        res.command_id   = cmd_reg;
        res.sequence_res = seq_reg;
        res.status       = ccfp_pkg::ST_OK;
        res.frame_last   = 1'b1;

        if (in_accept)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    fcrc_next = ccfp_pkg::crc16_byte(fcrc_reg, rx_byte);
                    if (pos_reg < 16'd4)
                    begin
                        hcrc_next = ccfp_pkg::crc8_byte(hcrc_reg, rx_byte);
                        if (pos_reg == 16'd1)
                        begin
                            len_next = {8'h00, rx_byte};
                        end
                        else if (pos_reg == 16'd2)
                        begin
                            len_next = {rx_byte, len_reg[7:0]};
                        end
                        else
                        begin
                            seq_next = rx_byte;
                        end
                        pos_next = pos_reg + 16'd1;
                    end
                    else
                    begin
                        // fifth byte carries the header crc
                        phase_next = PH_HUNT;
                        if (hcrc_reg != rx_byte)
                        begin
                            res_valid  = 1'b1;
                            res.status = ccfp_pkg::ST_HDR_CRC;
                        end
                        else if (len_reg > max_len_reg)
                        begin
                            res_valid  = 1'b1;
                            res.status = ccfp_pkg::ST_LEN;
                        end
                        else
                        begin
                            phase_next = PH_CMD;
                            pos_next   = 16'd0;
                        end
                    end
                end
                PH_CMD:
                begin
                    fcrc_next = ccfp_pkg::crc16_byte(fcrc_reg, rx_byte);
                    if (pos_reg == 16'd0)
                    begin
                        cmd_next = {8'h00, rx_byte};
                        pos_next = 16'd1;
                    end
                    else
                    begin
                        cmd_next   = {rx_byte, cmd_reg[7:0]};
                        pos_next   = 16'd0;
                        // empty payload goes straight to the trailer crc
                        phase_next = (len_reg == 16'd0) ? PH_CRC : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    fcrc_next      = ccfp_pkg::crc16_byte(fcrc_reg, rx_byte);
                    res_valid      = 1'b1;
                    res.kind       = ccfp_pkg::KIND_DATA;
                    res.data_byte  = rx_byte;
                    res.data_index = pos_reg;
                    res.frame_last = 1'b0;
                    if (data_done)
                    begin
                        phase_next = PH_CRC;
                        pos_next   = 16'd0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 16'd1;
                    end
                end
                PH_CRC:
                begin
                    if (pos_reg == 16'd0)
                    begin
                        crc_lo_next = rx_byte;
                        pos_next    = 16'd1;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                        pos_next   = 16'd0;
                        res_valid  = 1'b1;
                        res.status = (fcrc_reg == {rx_byte, crc_lo_reg}) ?
                                     ccfp_pkg::ST_OK : ccfp_pkg::ST_FRM_CRC;
                    end
                end
                default:
                begin
                    // hunt, and any stray phase code behaves as hunt
                    phase_next = PH_HUNT;
                    if (rx_byte == ccfp_pkg::SOF_BYTE)
                    begin
                        hcrc_next   = ccfp_pkg::crc8_byte(ccfp_pkg::HDR_CRC_INIT, rx_byte);
                        fcrc_next   = ccfp_pkg::crc16_byte(ccfp_pkg::FRM_CRC_INIT, rx_byte);
                        len_next    = 16'd0;
                        cmd_next    = 16'd0;
                        crc_lo_next = 8'h00;
                        pos_next    = 16'd1;
                        phase_next  = PH_HEADER;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            pos_reg     <= 16'd0;
            len_reg     <= 16'd0;
            hcrc_reg    <= ccfp_pkg::HDR_CRC_INIT;
            fcrc_reg    <= ccfp_pkg::FRM_CRC_INIT;
            seq_reg     <= 8'h00;
            cmd_reg     <= 16'd0;
            crc_lo_reg  <= 8'h00;
            max_len_reg <= ccfp_pkg::MAX_DATA_LEN_RST;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            hcrc_reg   <= hcrc_next;
            fcrc_reg   <= fcrc_next;
            seq_reg    <= seq_next;
            cmd_reg    <= cmd_next;
            crc_lo_reg <= crc_lo_next;
            if (cfg_wr_en)
            begin
                max_len_reg <= cfg_wr_data;
            end
        end
    end

    // result register; stalls the byte input only while it holds a result
    ccfp_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (res_valid),
        .load_data  (res),
        .out_stall  (out_stall),
        .hold       (in_stall),
        .out_valid  (out_valid),
        .out_data   (out_data)
    );

    assign kind         = out_data.kind;
    assign data_byte    = out_data.data_byte;
    assign data_index   = out_data.data_index;
    assign command_id   = out_data.command_id;
    assign sequence_res = out_data.sequence_res;
    assign status       = out_data.status;
    assign frame_last   = out_data.frame_last;

    // payload index always below the header length
    a_data_pos: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> pos_reg < len_reg)
        else $error("data position beyond frame length");

    // header position stays within the four header bytes plus crc
    a_hdr_pos: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> (pos_reg >= 16'd1 && pos_reg <= 16'd4))
        else $error("header position out of range");

    // start byte seen while hunting opens a header
    a_sof: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && phase_reg == PH_HUNT && rx_byte == ccfp_pkg::SOF_BYTE)
        |=> phase_reg == PH_HEADER)
        else $error("start byte did not open a header");

    // input held off only behind a waiting result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a pending result");

    // data items never carry a status or frame end
    a_data_item: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == ccfp_pkg::KIND_DATA) |-> (status == ccfp_pkg::ST_OK && !frame_last))
        else $error("data item carries report fields");

endmodule

[dv/crc_checked_frame_parser_unit_tb.sv]
// self-checking testbench for the crc checked frame parser: frame stimulus, shadow parser, checks
module crc_checked_frame_parser_unit_tb;

    // parser phases of the shadow model
    typedef enum logic [2:0] {PH_HUNT, PH_HEADER, PH_CMD, PH_DATA, PH_CRC} parse_phase_t;

    // how a generated frame is damaged on purpose
    typedef enum logic [1:0] {FLAW_NONE, FLAW_HDR_CRC, FLAW_FRM_CRC, FLAW_CUT} frame_flaw_t;

    localparam int CHUNK_BYTES = 170;   // frame bytes per random chunk
    localparam int NUM_CHUNKS  = 5;
    localparam int SETTLE_CYC  = 4;     // settling margin after the last expected result

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] data_index;
    logic [15:0] command_id;
    logic [7:0]  sequence_res;
    logic [1:0]  status;
    logic        frame_last;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'h0000;

    // stimulus and scoreboard storage
    logic [7:0]        pending_bytes[$];
    ccfp_pkg::result_t expected_results[$];
    int                err_count = 0;
    int                queued_count = 0;

    // idling knobs, percent chance of a gap / stall after each cycle slot
    int in_gap_pct = 0;
    int out_stall_pct = 0;
    int gap_left = 0;
    int stall_left = 0;

    // shadow copy of the parser state and the length limit
    parse_phase_t sh_phase = PH_HUNT;
    logic [15:0]  sh_pos = 16'h0000;
    logic [15:0]  sh_len = 16'h0000;
    logic [7:0]   sh_hcrc = ccfp_pkg::HDR_CRC_INIT;
    logic [15:0]  sh_fcrc = ccfp_pkg::FRM_CRC_INIT;
    logic [7:0]   sh_seq = 8'h00;
    logic [15:0]  sh_cmd = 16'h0000;
    logic [7:0]   sh_crc_lo = 8'h00;
    logic [15:0]  max_len = ccfp_pkg::MAX_DATA_LEN_RST;

    crc_checked_frame_parser_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .data_index   (data_index),
        .command_id   (command_id),
        .sequence_res (sequence_res),
        .status       (status),
        .frame_last   (frame_last),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #5 clk = ~clk;

    // bitwise reflected crc8, lsb of the byte enters first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       mix;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            mix = c[0] ^ b[i];
            c = c >> 1;
            if (mix)
                c = c ^ ccfp_pkg::HDR_CRC_POLY;
        end
        return c;
    endfunction

    // bitwise reflected ccitt crc16
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        mix;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            mix = c[0] ^ b[i];
            c = c >> 1;
            if (mix)
                c = c ^ ccfp_pkg::FRM_CRC_POLY;
        end
        return c;
    endfunction

    // mostly no gap, sometimes a short one, rarely a long one
    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    // result item built from the current shadow command and sequence
    function automatic ccfp_pkg::result_t make_result(input logic k, input logic [7:0] d,
                                                      input logic [15:0] idx,
                                                      input logic [1:0] st);
        ccfp_pkg::result_t r;
        r.kind         = k;
        r.data_byte    = d;
        r.data_index   = idx;
        r.command_id   = sh_cmd;
        r.sequence_res = sh_seq;
        r.status       = st;
        r.frame_last   = k;
        return r;
    endfunction

    // advance the shadow parser by one accepted byte, queue what it should emit
    function automatic void parse_byte(input logic [7:0] b);
        case (sh_phase)
            PH_HEADER:
            begin
                sh_fcrc = crc16_step(sh_fcrc, b);
                if (sh_pos < 16'd4)
                begin
                    sh_hcrc = crc8_step(sh_hcrc, b);
                    if (sh_pos == 16'd1)
                        sh_len = {8'h00, b};
                    else if (sh_pos == 16'd2)
                        sh_len[15:8] = b;
                    else
                        sh_seq = b;
                    sh_pos = sh_pos + 16'd1;
                end
                else if (sh_hcrc != b)
                begin
                    // header crc is checked before the length limit
                    sh_phase = PH_HUNT;
                    expected_results.push_back(make_result(ccfp_pkg::KIND_REPORT, 8'h00,
                                                           16'h0000, ccfp_pkg::ST_HDR_CRC));
                end
                else if (sh_len > max_len)
                begin
                    sh_phase = PH_HUNT;
                    expected_results.push_back(make_result(ccfp_pkg::KIND_REPORT, 8'h00,
                                                           16'h0000, ccfp_pkg::ST_LEN));
                end
                else
                begin
                    sh_phase = PH_CMD;
                    sh_pos = 16'h0000;
                end
            end
            PH_CMD:
            begin
                sh_fcrc = crc16_step(sh_fcrc, b);
                if (sh_pos == 16'h0000)
                begin
                    sh_cmd = {8'h00, b};
                    sh_pos = 16'd1;
                end
                else
                begin
                    // zero-length frames go straight to the crc bytes
                    sh_cmd[15:8] = b;
                    sh_pos = 16'h0000;
                    sh_phase = (sh_len == 16'h0000) ? PH_CRC : PH_DATA;
                end
            end
            PH_DATA:
            begin
                sh_fcrc = crc16_step(sh_fcrc, b);
                expected_results.push_back(make_result(ccfp_pkg::KIND_DATA, b, sh_pos,
                                                       ccfp_pkg::ST_OK));
                if ({16'h0000, sh_pos} + 32'd1 >= {16'h0000, sh_len})
                begin
                    sh_phase = PH_CRC;
                    sh_pos = 16'h0000;
                end
                else
                    sh_pos = sh_pos + 16'd1;
            end
            PH_CRC:
            begin
                if (sh_pos == 16'h0000)
                begin
                    sh_crc_lo = b;
                    sh_pos = 16'd1;
                end
                else
                begin
                    sh_phase = PH_HUNT;
                    sh_pos = 16'h0000;
                    if (sh_fcrc == {b, sh_crc_lo})
                        expected_results.push_back(make_result(ccfp_pkg::KIND_REPORT, 8'h00,
                                                               16'h0000, ccfp_pkg::ST_OK));
                    else
                        expected_results.push_back(make_result(ccfp_pkg::KIND_REPORT, 8'h00,
                                                               16'h0000,
                                                               ccfp_pkg::ST_FRM_CRC));
                end
            end
            default:
            begin
                // hunting: anything but the start byte is dropped silently
                sh_phase = PH_HUNT;
                if (b == ccfp_pkg::SOF_BYTE)
                begin
                    sh_hcrc   = crc8_step(ccfp_pkg::HDR_CRC_INIT, b);
                    sh_fcrc   = crc16_step(ccfp_pkg::FRM_CRC_INIT, b);
                    sh_len    = 16'h0000;
                    sh_cmd    = 16'h0000;
                    sh_crc_lo = 8'h00;
                    sh_pos    = 16'd1;
                    sh_phase  = PH_HEADER;
                end
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endfunction

    // input driver: pulls bytes from the pending queue, random gaps between items
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            // an accepted byte updates the shadow parser right away
            if (in_valid && !in_stall)
                parse_byte(rx_byte);
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_bytes.size() > 0)
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= pending_bytes.pop_front();
                    gap_left <= pick_gap(in_gap_pct);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor: random back-pressure, compares every accepted item in order
    always @(posedge clk)
    begin
        ccfp_pkg::result_t want;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item with nothing expected: kind %0d status %0d",
                           kind, status);
                    err_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("kind", 16'(want.kind), 16'(kind));
                    check_field("data_byte", 16'(want.data_byte), 16'(data_byte));
                    check_field("data_index", want.data_index, data_index);
                    check_field("command_id", want.command_id, command_id);
                    check_field("sequence_res", 16'(want.sequence_res), 16'(sequence_res));
                    check_field("status", 16'(want.status), 16'(status));
                    check_field("frame_last", 16'(want.frame_last), 16'(frame_last));
                end
            end
            if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left <= pick_gap(out_stall_pct);
            end
        end
    end

    // wait until every queued byte is taken and every expected item has come back
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        // a trailing hunt byte produces nothing, so give the pipe time to drain
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // limit register is only touched once every queued byte is taken and every expected item is back
    task automatic set_max_len(input logic [15:0] v);
        wait_idle();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        max_len = v;
    endtask

    // queue one frame; over-limit and bad header frames stop after the header crc
    task automatic queue_frame(input logic [15:0] len, input logic [15:0] cid,
                               input logic [7:0] sq, input frame_flaw_t flaw);
        logic [7:0]  fb[$];
        logic [7:0]  hc;
        logic [15:0] fc;
        int          keep;
        fb = {ccfp_pkg::SOF_BYTE, len[7:0], len[15:8], sq};
        hc = ccfp_pkg::HDR_CRC_INIT;
        foreach (fb[i])
            hc = crc8_step(hc, fb[i]);
        if (flaw == FLAW_HDR_CRC)
            hc = hc ^ 8'($urandom_range(1, 255));
        fb.push_back(hc);
        if (flaw != FLAW_HDR_CRC && len <= max_len)
        begin
            fb.push_back(cid[7:0]);
            fb.push_back(cid[15:8]);
            repeat (len) fb.push_back(8'($urandom));
            // frame crc covers everything before it, header crc byte included
            fc = ccfp_pkg::FRM_CRC_INIT;
            foreach (fb[i])
                fc = crc16_step(fc, fb[i]);
            if (flaw == FLAW_FRM_CRC)
                fc = fc ^ 16'($urandom_range(1, 65535));
            fb.push_back(fc[7:0]);
            fb.push_back(fc[15:8]);
        end
        keep = (flaw == FLAW_CUT) ? $urandom_range(1, fb.size() - 1) : fb.size();
        for (int i = 0; i < keep; i++)
            pending_bytes.push_back(fb[i]);
        queued_count += keep;
    endtask

    // data lengths: mostly tiny, some medium, a few up to 64
    function automatic logic [15:0] pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 16'($urandom_range(0, 6));
        if (r < 90)
            return 16'($urandom_range(7, 24));
        return 16'($urandom_range(25, 64));
    endfunction

    initial
    begin
        int          r;
        int          over;
        logic [15:0] len;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default limit, stray bytes while hunting, one of each report
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        queue_frame(16'd0, 16'hFFFF, 8'hFF, FLAW_NONE);
        queue_frame(16'd2, 16'h0000, 8'h00, FLAW_NONE);
        queue_frame(16'd1, 16'h1234, 8'h5A, FLAW_HDR_CRC);
        queue_frame(16'd129, 16'h0001, 8'h80, FLAW_NONE);
        queue_frame(16'd3, 16'h8000, 8'h01, FLAW_FRM_CRC);

        // limit of zero: only empty frames get through
        set_max_len(16'h0000);
        queue_frame(16'd0, 16'h00FF, 8'h7F, FLAW_NONE);
        queue_frame(16'd1, 16'hFF00, 8'hFE, FLAW_NONE);

        // largest length field, once with a bad header crc under the full limit, once just above the limit
        set_max_len(16'hFFFF);
        queue_frame(16'hFFFF, 16'h5555, 8'hAA, FLAW_HDR_CRC);
        set_max_len(16'hFFFE);
        queue_frame(16'hFFFF, 16'hAAAA, 8'h55, FLAW_NONE);

        // length exactly at the limit and one past it
        set_max_len(16'd3);
        queue_frame(16'd3, 16'h0F0F, 8'h10, FLAW_NONE);
        queue_frame(16'd4, 16'hF0F0, 8'h20, FLAW_NONE);

        // random chunks, each with its own limit and idling mix
        for (int c = 0; c < NUM_CHUNKS; c++)
        begin
            case (c)
                0:       set_max_len(ccfp_pkg::MAX_DATA_LEN_RST);
                1:       set_max_len(16'($urandom_range(1, 40)));
                2:       set_max_len(16'h0000);
                3:       set_max_len(16'hFFFF);
                default: set_max_len(16'($urandom_range(0, 16)));
            endcase
            // one chunk runs flat out with no idling on either side
            if (c == 2)
            begin
                in_gap_pct    = 0;
                out_stall_pct = 0;
            end
            else
            begin
                in_gap_pct    = $urandom_range(10, 60);
                out_stall_pct = $urandom_range(10, 60);
            end
            queued_count = 0;
            while (queued_count < CHUNK_BYTES)
            begin
                r   = $urandom_range(99);
                len = pick_len();
                if (r < 70 || r >= 86)
                    len = 16'(int'(len) % (int'(max_len) + 1));
                if (r < 8)
                begin
                    // line noise between frames, may hold a stray start byte
                    repeat ($urandom_range(1, 4)) pending_bytes.push_back(8'($urandom));
                end
                else if (r < 70)
                    queue_frame(len, 16'($urandom), 8'($urandom), FLAW_NONE);
                else if (r < 78 || (r < 86 && max_len == 16'hFFFF))
                    queue_frame(len, 16'($urandom), 8'($urandom), FLAW_HDR_CRC);
                else if (r < 86)
                begin
                    over = int'(max_len) + 1 + $urandom_range(0, 40);
                    if (over > 65535)
                        over = 65535;
                    queue_frame(16'(over), 16'($urandom), 8'($urandom), FLAW_NONE);
                end
                else if (r < 94)
                    queue_frame(len, 16'($urandom), 8'($urandom), FLAW_FRM_CRC);
                else
                    queue_frame(len, 16'($urandom), 8'($urandom), FLAW_CUT);
            end
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (err_count == 0 && expected_results.size() == 0)
            $display("crc_checked_frame_parser_unit_tb: done, clean");
        else
            $display("crc_checked_frame_parser_unit_tb: done, errors");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #3000000;
        $display("crc_checked_frame_parser_unit_tb: done, errors");
        $finish;
    end

endmodule
